// ===== rtl/core/ipv4p_pkg.sv =====
// Shared types and constants for the IPv4 text address parser.
`default_nettype none

package ipv4p_pkg;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [9:0] OCTET_MAX        = 10'd255;
    localparam logic [2:0] OCTET_DIGITS_MAX = 3'd3;
    localparam logic [2:0] PORT_DIGITS      = 3'd5;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HEAD1 = 3'd1,
        PH_HEAD2 = 3'd2,
        PH_HEAD3 = 3'd3,
        PH_LAST  = 3'd4,
        PH_PORT  = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  digit_count;
        logic [9:0]  octet_value;
        logic [23:0] upper_octets;
        logic [4:0]  length_so_far;
    } parse_state_t;

    typedef struct packed {
        logic        empty_octet;
        logic [31:0] address;
        logic [4:0]  consumed;
        logic        valid_res;
    } parse_result_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:         PH_IDLE,
        digit_count:   3'd0,
        octet_value:   10'd0,
        upper_octets:  24'd0,
        length_so_far: 5'd0
    };

endpackage

`default_nettype wire

// ===== rtl/core/ipv4p_step.sv =====
// Next-state and result logic for one character of the address parser.
`default_nettype none

module ipv4p_step
    import ipv4p_pkg::*;
(
    input  wire logic [7:0]    ch,
    input  wire logic          start_req,
    input  wire parse_state_t  state_cur,
    output parse_state_t       state_next,
    output logic               emit,
    output parse_result_t      result
);

    parse_state_t  st;
    logic          is_digit;
    logic [3:0]    dval;
    logic [9:0]    ov_acc;
    logic [2:0]    dc_inc;
    logic [4:0]    len_inc;
    logic [31:0]   addr_full;
    logic          octet_big;
    logic          can_take_digit;

    // A start mark restarts the token on this very character.
    always_comb
    begin
        if (start_req)
        begin
            st       = STATE_CLEAR;
            st.phase = PH_HEAD1;
        end
        else
        begin
            st = state_cur;
        end
    end

    assign is_digit       = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign dval           = 4'(ch - CH_ZERO);
    assign ov_acc         = (st.octet_value << 3) + (st.octet_value << 1) + {6'd0, dval};
    assign dc_inc         = st.digit_count + 3'd1;
    assign len_inc        = st.length_so_far + 5'd1;
    assign addr_full      = {st.upper_octets, st.octet_value[7:0]};
    assign octet_big      = st.octet_value > OCTET_MAX;
    assign can_take_digit = is_digit && (st.digit_count < OCTET_DIGITS_MAX);

    always_comb
    begin
        state_next = st;
        emit       = 1'b0;
        result     = '0;
        unique case (st.phase)
            PH_HEAD1, PH_HEAD2, PH_HEAD3:
            begin
                if (can_take_digit)
                begin
                    state_next.octet_value   = ov_acc;
                    state_next.digit_count   = dc_inc;
                    state_next.length_so_far = len_inc;
                end
                else if (st.digit_count == 3'd0)
                begin
                    emit               = 1'b1;
                    result.empty_octet = 1'b1;
                end
                else if ((ch != CH_DOT) || octet_big)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    case (st.phase)
                        PH_HEAD1: state_next.upper_octets[23:16] = st.octet_value[7:0];
                        PH_HEAD2: state_next.upper_octets[15:8]  = st.octet_value[7:0];
                        default:  state_next.upper_octets[7:0]   = st.octet_value[7:0];
                    endcase
                    state_next.length_so_far = len_inc;
                    state_next.digit_count   = 3'd0;
                    state_next.octet_value   = 10'd0;
                    state_next.phase         = phase_t'(st.phase + 3'd1);
                end
            end
            PH_LAST:
            begin
                if (can_take_digit)
                begin
                    state_next.octet_value   = ov_acc;
                    state_next.digit_count   = dc_inc;
                    state_next.length_so_far = len_inc;
                end
                else if ((st.digit_count == 3'd0) || octet_big)
                begin
                    emit = 1'b1;
                end
                else if (ch == CH_COLON)
                begin
                    state_next.length_so_far = len_inc;
                    state_next.digit_count   = 3'd0;
                    state_next.phase         = PH_PORT;
                end
                else
                begin
                    emit             = 1'b1;
                    result.valid_res = 1'b1;
                    result.consumed  = st.length_so_far;
                    result.address   = addr_full;
                end
            end
            PH_PORT:
            begin
                if (is_digit)
                begin
                    state_next.digit_count   = dc_inc;
                    state_next.length_so_far = len_inc;
                    // Fifth port digit closes the token without a terminator.
                    if (dc_inc >= PORT_DIGITS)
                    begin
                        emit             = 1'b1;
                        result.valid_res = 1'b1;
                        result.consumed  = len_inc;
                        result.address   = addr_full;
                    end
                end
                else if (st.digit_count == 3'd0)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    emit             = 1'b1;
                    result.valid_res = 1'b1;
                    result.consumed  = st.length_so_far;
                    result.address   = addr_full;
                end
            end
            default:
            begin
                state_next.phase = PH_IDLE;
            end
        endcase
        if (emit)
        begin
            state_next = STATE_CLEAR;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ipv4_text_address_parser.sv =====
// Top level of the streaming IPv4 dotted-quad text parser.
`default_nettype none

// Takes one character per cycle on the slave stream (tuser marks the first character
// of a token) and returns one result word when a token ends: the character that
// cannot continue it, or the fifth port digit. The running parse state is a single
// register updated once per accepted character, so a character can be taken every
// cycle; the result word appears on the master stream on the cycle after the
// character that ends the token and sits in an output register, which lets input
// continue while the master side is ready. Input stalls only while that register holds
// an untaken result and the master side is not ready.
module ipv4_text_address_parser
    import ipv4p_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] ch
    input  wire logic                  s_axis_tuser,  // [0] start_req
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] valid_res, [5:1] consumed, [37:6] address, [38] empty_octet, [39] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_result;
    parse_result_t result_reg;
    logic          step_emit;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          in_acc;

    ipv4p_step u_step (
        .ch         (s_axis_tdata),
        .start_req  (s_axis_tuser),
        .state_cur  (state_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (in_acc && step_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_acc)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Hold the payload until a new result replaces it.
    always_ff @(posedge clk)
    begin
        if (in_acc && step_emit)
        begin
            result_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, result_reg};

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && step_emit) |=> (state_reg.phase == PH_IDLE) &&
                                  (state_reg.length_so_far == 5'd0) &&
                                  (state_reg.upper_octets == 24'd0))
        else $error("parse state not cleared after a result");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !result_reg.valid_res) |->
            (result_reg.consumed == 5'd0) && (result_reg.address == 32'd0))
        else $error("invalid result carries length or address");

    a_valid_length: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && result_reg.valid_res) |->
            (result_reg.consumed >= 5'd7) && (result_reg.consumed <= 5'd21) &&
            !result_reg.empty_octet)
        else $error("valid result with impossible length or empty octet");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.length_so_far <= 5'd21)
        else $error("consumed length overran");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while an untaken result is held");

endmodule

`default_nettype wire

// ===== tb/sv/ipv4_address_result_checker.sv =====
// Checker for the IPv4 text parser: predicts each result word and compares it.
`timescale 1ns / 1ps

module ipv4_address_result_checker
    import ipv4p_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic                  s_axis_tuser,   // [0] start_req
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] valid_res, [5:1] consumed, [37:6] address, [38] empty_octet, [39] zero
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                         mismatches,
    output int                         pending
);

    // Running parse of the current token
    phase_t      ph         = PH_IDLE;
    logic [2:0]  ndig       = '0;
    logic [9:0]  oval       = '0;
    logic [23:0] head_bytes = '0;
    logic [4:0]  taken      = '0;

    parse_result_t due_results[$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("ERROR at %0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_token();
        ndig       = '0;
        oval       = '0;
        head_bytes = '0;
        taken      = '0;
    endtask

    task automatic add_digit(input logic [3:0] dv);
        oval = oval * 10 + dv;
        ndig++;
        taken++;
    endtask

    task automatic close_token(input logic ok, input logic [31:0] addr, input logic empty);
        parse_result_t r;
        r.valid_res   = ok;
        r.consumed    = ok ? taken : 5'd0;
        r.address     = ok ? addr : 32'd0;
        r.empty_octet = empty;
        due_results.push_back(r);
        ph = PH_IDLE;
        clear_token();
    endtask

    task automatic step_parser(input logic [7:0] c, input logic st);
        logic        is_dig;
        logic [3:0]  dv;
        logic [31:0] addr;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        dv     = 4'(c - CH_ZERO);
        if (st)
        begin
            // drop any token in progress
            ph = PH_HEAD1;
            clear_token();
        end
        addr = {head_bytes, oval[7:0]};
        case (ph)
            PH_HEAD1, PH_HEAD2, PH_HEAD3:
            begin
                if (is_dig && ndig < OCTET_DIGITS_MAX)
                    add_digit(dv);
                else if (ndig == 0)
                    close_token(1'b0, 32'd0, 1'b1);
                else if (c != CH_DOT || oval > OCTET_MAX)
                    close_token(1'b0, 32'd0, 1'b0);
                else
                begin
                    case (ph)
                        PH_HEAD1: head_bytes[23:16] = oval[7:0];
                        PH_HEAD2: head_bytes[15:8]  = oval[7:0];
                        default:  head_bytes[7:0]   = oval[7:0];
                    endcase
                    taken++;
                    ndig = '0;
                    oval = '0;
                    ph   = (ph == PH_HEAD1) ? PH_HEAD2 : (ph == PH_HEAD2) ? PH_HEAD3 : PH_LAST;
                end
            end
            PH_LAST:
            begin
                // a fourth digit falls through here and ends the token unconsumed
                if (is_dig && ndig < OCTET_DIGITS_MAX)
                    add_digit(dv);
                else if (ndig == 0 || oval > OCTET_MAX)
                    close_token(1'b0, 32'd0, 1'b0);
                else if (c == CH_COLON)
                begin
                    taken++;
                    ndig = '0;
                    ph   = PH_PORT;
                end
                else
                    close_token(1'b1, addr, 1'b0);
            end
            PH_PORT:
            begin
                if (is_dig)
                begin
                    ndig++;
                    taken++;
                    if (ndig >= PORT_DIGITS)
                        close_token(1'b1, addr, 1'b0);
                end
                else if (ndig == 0)
                    close_token(1'b0, 32'd0, 1'b0);
                else
                    close_token(1'b1, addr, 1'b0);
            end
            default:
                ph = PH_IDLE;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t got;
        parse_result_t want;
        if (!rst_n)
        begin
            ph = PH_IDLE;
            clear_token();
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = parse_result_t'(m_axis_tdata[38:0]);
                if (due_results.size() == 0)
                    report_mismatch("result word with none expected", m_axis_tdata, '0);
                else
                begin
                    want = due_results.pop_front();
                    if (got.valid_res !== want.valid_res)
                        report_mismatch("valid_res", 40'(got.valid_res),
                                        40'(want.valid_res));
                    if (got.consumed !== want.consumed)
                        report_mismatch("consumed", 40'(got.consumed), 40'(want.consumed));
                    if (got.address !== want.address)
                        report_mismatch("address", 40'(got.address), 40'(want.address));
                    if (got.empty_octet !== want.empty_octet)
                        report_mismatch("empty_octet", 40'(got.empty_octet),
                                        40'(want.empty_octet));
                    if (m_axis_tdata[39] !== 1'b0)
                        report_mismatch("pad bit", 40'(m_axis_tdata[39]), 40'd0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                step_parser(s_axis_tdata, s_axis_tuser);
            pending <= due_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_ipv4_text_address_parser.sv =====
// Testbench top for the IPv4 text parser: drives character words and gives the verdict.
`timescale 1ns / 1ps

module tb_ipv4_text_address_parser;
    import ipv4p_pkg::*;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [7:0] ch
    logic                  s_axis_tuser  = 1'b0;  // [0] start_req
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] valid_res, [5:1] consumed, [37:6] address, [38] empty_octet, [39] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int mismatches;
    int pending;

    int  chars_sent = 0;
    int  burst_left = 0;
    bit  hold_req   = 1'b0;
    bit  hold_on    = 1'b0;
    logic [7:0] text_q[$];

    ipv4_text_address_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ipv4_address_result_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("ipv4_text_address_parser: mismatch");
        $finish;
    end

    // Receiver: ready patterns of varying density, plus one long hold-off on request
    initial
    begin
        int mode;
        int span;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_on = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
                hold_on  = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 80);
                repeat (span)
                begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Offer one word and hold it until taken; tvalid stays up for the caller
    task automatic send_word(input logic [7:0] c, input logic st);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= st;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        chars_sent++;
    endtask

    task automatic paced_send(input logic [7:0] c, input logic st);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        send_word(c, st);
    endtask

    task automatic send_token();
        for (int k = 0; k < text_q.size(); k++)
            paced_send(text_q[k], k == 0);
    endtask

    task automatic send_string(input string t);
        text_q.delete();
        for (int k = 0; k < t.len(); k++)
            text_q.push_back(t[k]);
        send_token();
    endtask

    // Lower tvalid and wait until every predicted result word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Build a dotted-quad token, mostly well formed, sometimes damaged
    task automatic make_token();
        int unsigned val;
        int          d[3];
        int          nd;
        int          pick;
        int          pos;
        int          bad_octet;
        bit          cut;
        text_q.delete();
        cut       = 1'b0;
        pick      = $urandom_range(0, 9);
        bad_octet = (pick == 3) ? $urandom_range(0, 3) : -1;
        for (int o = 0; o < 4; o++)
        begin
            case ($urandom_range(0, 9))
                0:       val = 0;
                1:       val = 255;
                default: val = $urandom_range(0, 255);
            endcase
            if (o == bad_octet)
                val = $urandom_range(256, 999);
            d[0] = val % 10;
            d[1] = (val / 10) % 10;
            d[2] = val / 100;
            nd   = (val >= 100) ? 3 : (val >= 10) ? 2 : 1;
            // leading zeros now and then
            if ($urandom_range(0, 5) == 0)
                nd = $urandom_range(nd, 3);
            for (int k = nd - 1; k >= 0; k--)
                text_q.push_back(CH_ZERO + 8'(d[k]));
            if (o < 3)
                text_q.push_back(CH_DOT);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            text_q.push_back(CH_COLON);
            repeat ($urandom_range(1, 5))
                text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        pos = $urandom_range(0, text_q.size() - 1);
        case (pick)
            0: text_q[pos] = 8'($urandom_range(0, 255));
            1: text_q.delete(pos);
            2: text_q.insert(pos, ($urandom_range(0, 1) == 1) ? CH_ZERO + 8'($urandom_range(0, 9))
                                                               : 8'($urandom_range(0, 255)));
            4:
            begin
                // leave the token open; the next start drops it
                while (text_q.size() > pos + 1)
                    void'(text_q.pop_back());
                cut = 1'b1;
            end
            default: ;
        endcase
        if (!cut)
        begin
            case ($urandom_range(0, 5))
                0:       text_q.push_back(8'h20);
                1:       text_q.push_back(8'h00);
                2:       text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                3:       text_q.push_back(8'h2F);
                default: text_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial
    begin
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        while (!rst_n) @(posedge clk);

        // Idle bytes at both ends of the range, then the short corner tokens
        paced_send(8'hFF, 1'b0);
        paced_send(8'h00, 1'b0);
        send_string(".");
        send_string("256.");
        send_string("1234");
        send_string("0.0.0.0:00000");

        while (chars_sent < 1150)
        begin
            if (!held && chars_sent >= 450)
            begin
                // hold the receiver off and keep pushing one-character tokens
                s_axis_tvalid <= 1'b0;
                hold_req = 1'b1;
                @(posedge clk);
                while (!hold_on) @(posedge clk);
                repeat (40)
                    send_word(CH_DOT, 1'b1);
                held = 1'b1;
            end
            if (!paused && chars_sent >= 800)
            begin
                drain_results();
                paused = 1'b1;
            end
            make_token();
            send_token();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    paced_send(8'($urandom_range(0, 255)), 1'b0);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ipv4_text_address_parser: match");
        else
            $display("ipv4_text_address_parser: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ipv4p_pkg.sv
rtl/core/ipv4p_step.sv
rtl/core/ipv4_text_address_parser.sv
tb/sv/ipv4_address_result_checker.sv
tb/sv/tb_ipv4_text_address_parser.sv
